[hdl/cbs_pkg.sv]
// shared types and constants for the challenge ball sampler
package cbs_pkg;

    localparam int MODULUS_DEF  = 8380417;
    localparam int POLY_LEN_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 8;
    localparam int COEFF_W  = 23;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 7;
    localparam int SIGN_W   = 64;
    localparam int PLACE_W  = 9;
    localparam int SCNT_W   = 4;

    localparam logic [CNT_W-1:0]  NZ_COUNT_RST = 7'd60;
    localparam logic [CNT_W-1:0]  MAX_NONZERO  = 7'd64;
    localparam logic [SCNT_W-1:0] SIGN_BYTES   = 4'd8;

    localparam logic [1:0] COEF_ZERO  = 2'd0;
    localparam logic [1:0] COEF_PLUS  = 2'd1;
    localparam logic [1:0] COEF_MINUS = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_SIGN_TAKEN  = 3'd0,
        ST_REJECTED    = 3'd1,
        ST_PLACED      = 3'd2,
        ST_PLACED_DONE = 3'd3,
        ST_IGNORED     = 3'd4,
        ST_STARTED     = 3'd5,
        ST_READ        = 3'd6
    } t_status;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        wr_data;
    } t_store_cmd;

endpackage

[hdl/cbs_req_if.sv]
// request channel: start, hash byte or coefficient read
interface cbs_req_if;
    logic                        valid;
    logic                        ready;
    logic [cbs_pkg::REQ_W-1:0]   req_type;
    logic [cbs_pkg::BYTE_W-1:0]  hash_byte;
    logic [cbs_pkg::BYTE_W-1:0]  read_index;

    modport source (output valid, output req_type, output hash_byte, output read_index,
                    input ready);
    modport sink   (input valid, input req_type, input hash_byte, input read_index,
                    output ready);
endinterface

[hdl/cbs_rsp_if.sv]
// response channel: coefficient, status and finished flag
interface cbs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cbs_pkg::COEFF_W-1:0]   coeff_value;
    logic [cbs_pkg::STATUS_W-1:0]  status;
    logic                          finished;

    modport source (output valid, output coeff_value, output status, output finished,
                    input ready);
    modport sink   (input valid, input coeff_value, input status, input finished,
                    output ready);
endinterface

[hdl/cbs_cfg_if.sv]
// configuration write channel for the nonzero count
interface cbs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cbs_pkg::CNT_W-1:0]   nonzero_count;

    modport source (output valid, output nonzero_count, input ready);
    modport sink   (input valid, input nonzero_count, output ready);
endinterface

[hdl/cbs_store.sv]
// coefficient store: memory with one read and one write port, per-entry valid bits and registered read
module cbs_store #(
    parameter int POLY_LEN = cbs_pkg::POLY_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbs_pkg::t_store_cmd i_cmd,
    output logic [1:0]          o_rd_data
);

    localparam int AW = $clog2(POLY_LEN);

    logic [1:0]          r_mem [POLY_LEN];
    logic [POLY_LEN-1:0] r_vld;
    logic [1:0]          r_rd_mem;
    logic                r_rd_vld;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;

    assign rd_addr = i_cmd.rd_addr[AW-1:0];
    assign wr_addr = i_cmd.wr_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= i_cmd.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_mem <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vld <= '0;
            end else if (i_cmd.wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_mem : cbs_pkg::COEF_ZERO;

endmodule

[hdl/challenge_ball_sampler.sv]
// challenge ball sampler top: request decode, sampling control and response register
// start, sign byte, reject, ignore: result in the output register in the cycle after the beat
// read: the registered store read, then the output register; placement: one read, then two writes
// through the single store write port; one request in flight, next beat taken only in idle with the output free
// reset: count 60, store empty, sign word clear, as if a start had just been taken
module challenge_ball_sampler #(
    parameter int MODULUS  = cbs_pkg::MODULUS_DEF,
    parameter int POLY_LEN = cbs_pkg::POLY_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbs_req_if.sink   i_req,
    cbs_rsp_if.source o_rsp,
    cbs_cfg_if.sink   i_cfg
);

    localparam logic [cbs_pkg::PLACE_W-1:0] LEN9      = cbs_pkg::PLACE_W'(POLY_LEN);
    localparam logic [cbs_pkg::COEFF_W-1:0] MINUS_VAL = cbs_pkg::COEFF_W'(MODULUS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOVE,
        S_SIGN
    } t_state;

    t_state                           r_state,    n_state;
    logic [cbs_pkg::CNT_W-1:0]        r_nz_count;
    logic [cbs_pkg::SIGN_W-1:0]       r_sign_word, n_sign_word;
    logic [cbs_pkg::SCNT_W-1:0]       r_sign_cnt, n_sign_cnt;
    logic [cbs_pkg::PLACE_W-1:0]      r_place_idx, n_place_idx;
    logic                             r_done,     n_done;
    logic [cbs_pkg::BYTE_W-1:0]       r_byte,     n_byte;
    logic                             r_rd_ok,    n_rd_ok;
    logic                             r_out_vld,  n_out_vld;
    logic [cbs_pkg::COEFF_W-1:0]      r_coeff,    n_coeff;
    logic [cbs_pkg::STATUS_W-1:0]     r_status,   n_status;
    logic                             r_fin,      n_fin;

    cbs_pkg::t_store_cmd              store_cmd;
    logic [1:0]                       rd_data;
    logic                             accept;
    logic [cbs_pkg::CNT_W-1:0]        cnt_eff;
    logic [cbs_pkg::PLACE_W-1:0]      place_inc;

    cbs_store #(
        .POLY_LEN (POLY_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.coeff_value = r_coeff;
    assign o_rsp.status      = r_status;
    assign o_rsp.finished    = r_fin;

    assign place_inc = r_place_idx + 9'd1;

    always_comb begin
        cnt_eff = r_nz_count;
        if (cnt_eff > cbs_pkg::MAX_NONZERO) begin
            cnt_eff = cbs_pkg::MAX_NONZERO;
        end
        if ({2'b00, cnt_eff} > LEN9) begin
            cnt_eff = LEN9[cbs_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sign_word = r_sign_word;
        n_sign_cnt  = r_sign_cnt;
        n_place_idx = r_place_idx;
        n_done      = r_done;
        n_byte      = r_byte;
        n_rd_ok     = r_rd_ok;
        n_out_vld   = r_out_vld && !o_rsp.ready;
        n_coeff     = r_coeff;
        n_status    = r_status;
        n_fin       = r_fin;
        store_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_vld = 1'b1;
                    n_coeff   = '0;
                    n_fin     = r_done;
                    case (i_req.req_type)
                        cbs_pkg::REQ_START: begin
                            store_cmd.clear = 1'b1;
                            n_sign_word     = '0;
                            n_sign_cnt      = '0;
                            n_place_idx     = LEN9 - {2'b00, cnt_eff};
                            n_done          = (cnt_eff == '0);
                            n_status        = cbs_pkg::ST_STARTED;
                            n_fin           = (cnt_eff == '0);
                        end
                        cbs_pkg::REQ_BYTE: begin
                            if (r_done) begin
                                n_status = cbs_pkg::ST_IGNORED;
                            end else if (r_sign_cnt < cbs_pkg::SIGN_BYTES) begin
                                n_sign_word = {i_req.hash_byte, r_sign_word[63:8]};
                                n_sign_cnt  = r_sign_cnt + 4'd1;
                                n_status    = cbs_pkg::ST_SIGN_TAKEN;
                            end else if ({1'b0, i_req.hash_byte} > r_place_idx ||
                                         r_place_idx >= LEN9) begin
                                n_status = cbs_pkg::ST_REJECTED;
                            end else begin
                                store_cmd.rd_en   = 1'b1;
                                store_cmd.rd_addr = i_req.hash_byte;
                                n_byte            = i_req.hash_byte;
                                n_out_vld         = r_out_vld && !o_rsp.ready;
                                n_state           = S_MOVE;
                            end
                        end
                        cbs_pkg::REQ_READ: begin
                            n_rd_ok           = ({1'b0, i_req.read_index} < LEN9);
                            store_cmd.rd_en   = ({1'b0, i_req.read_index} < LEN9);
                            store_cmd.rd_addr = i_req.read_index;
                            n_out_vld         = r_out_vld && !o_rsp.ready;
                            n_state           = S_READ;
                        end
                        default: begin
                            n_status = cbs_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_vld = 1'b1;
                n_status  = cbs_pkg::ST_READ;
                n_fin     = r_done;
                n_coeff   = '0;
                if (r_rd_ok) begin
                    case (rd_data)
                        cbs_pkg::COEF_PLUS:  n_coeff = 23'd1;
                        cbs_pkg::COEF_MINUS: n_coeff = MINUS_VAL;
                        default:             n_coeff = '0;
                    endcase
                end
                n_state = S_IDLE;
            end
            S_MOVE: begin
                store_cmd.wr_en   = 1'b1;
                store_cmd.wr_addr = r_place_idx[cbs_pkg::ADDR_W-1:0];
                store_cmd.wr_data = rd_data;
                n_state           = S_SIGN;
            end
            S_SIGN: begin
                store_cmd.wr_en   = 1'b1;
                store_cmd.wr_addr = r_byte;
                store_cmd.wr_data = r_sign_word[0] ? cbs_pkg::COEF_MINUS : cbs_pkg::COEF_PLUS;
                n_sign_word       = {1'b0, r_sign_word[63:1]};
                n_place_idx       = place_inc;
                n_done            = (place_inc >= LEN9);
                n_out_vld         = 1'b1;
                n_coeff           = '0;
                n_status          = (place_inc >= LEN9) ? cbs_pkg::ST_PLACED_DONE
                                                        : cbs_pkg::ST_PLACED;
                n_fin             = (place_inc >= LEN9);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nz_count  <= cbs_pkg::NZ_COUNT_RST;
            r_sign_word <= '0;
            r_sign_cnt  <= '0;
            r_place_idx <= LEN9 - {2'b00, cbs_pkg::NZ_COUNT_RST};
            r_done      <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sign_word <= n_sign_word;
            r_sign_cnt  <= n_sign_cnt;
            r_place_idx <= n_place_idx;
            r_done      <= n_done;
            r_rd_ok     <= n_rd_ok;
            r_out_vld   <= n_out_vld;
            if (i_cfg.valid) begin
                r_nz_count <= i_cfg.nonzero_count;
            end
        end
        r_byte   <= n_byte;
        r_coeff  <= n_coeff;
        r_status <= n_status;
        r_fin    <= n_fin;
    end

    a_place_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_place_idx <= LEN9)
        else $error("place index beyond polynomial length");

    a_busy_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept)
        else $error("request beat taken while a request is in flight");

    a_move_preconds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |-> (!r_done && r_sign_cnt == cbs_pkg::SIGN_BYTES))
        else $error("placement without full sign word or after finish");

    a_sign_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |=> (r_out_vld && (r_status == cbs_pkg::ST_PLACED ||
                                 r_status == cbs_pkg::ST_PLACED_DONE)))
        else $error("placement did not produce a placed result");

endmodule

[tb/challenge_ball_sampler_tb.sv]
// testbench for challenge_ball_sampler: directed and random request streams checked beat by beat
`timescale 1ns / 1ps

module challenge_ball_sampler_tb;

    localparam logic [cbs_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [cbs_pkg::COEFF_W-1:0] coeff_value;
        cbs_pkg::t_status            status;
        logic                        finished;
    } t_sampler_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cbs_req_if req_if ();
    cbs_rsp_if rsp_if ();
    cbs_cfg_if cfg_if ();

    challenge_ball_sampler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // model of the sampler state
    logic [1:0]                   coef_img [cbs_pkg::POLY_LEN_DEF];
    logic [cbs_pkg::SIGN_W-1:0]   sign_bits;
    int                           signs_taken;
    int                           slot_idx;
    bit                           ball_done;
    logic [cbs_pkg::CNT_W-1:0]    nz_count_reg;

    t_sampler_rsp due_rsp_q [$];
    int           err_cnt = 0;
    int           items_counted = 0;
    int           burst_left = 0;
    bit           hold_rsp_req = 1'b0;
    int unsigned  cycle_cnt = 0;

    function automatic void restart_ball();
        int cnt;
        cnt = int'(nz_count_reg);
        if (cnt > int'(cbs_pkg::MAX_NONZERO)) cnt = int'(cbs_pkg::MAX_NONZERO);
        if (cnt > cbs_pkg::POLY_LEN_DEF) cnt = cbs_pkg::POLY_LEN_DEF;
        for (int k = 0; k < cbs_pkg::POLY_LEN_DEF; k++) coef_img[k] = cbs_pkg::COEF_ZERO;
        sign_bits   = '0;
        signs_taken = 0;
        slot_idx    = cbs_pkg::POLY_LEN_DEF - cnt;
        ball_done   = (cnt == 0);
    endfunction

    function automatic t_sampler_rsp predict_sampler_rsp(
            input logic [cbs_pkg::REQ_W-1:0] kind,
            input logic [cbs_pkg::BYTE_W-1:0] hb, input logic [cbs_pkg::ADDR_W-1:0] ridx);
        t_sampler_rsp r;
        r.coeff_value = '0;
        r.status      = cbs_pkg::ST_IGNORED;
        case (kind)
            cbs_pkg::REQ_START: begin
                restart_ball();
                r.status = cbs_pkg::ST_STARTED;
            end
            cbs_pkg::REQ_BYTE: begin
                if (ball_done) begin
                    r.status = cbs_pkg::ST_IGNORED;
                end else if (signs_taken < cbs_pkg::SIGN_BYTES) begin
                    sign_bits = sign_bits | (cbs_pkg::SIGN_W'(hb) << (8 * signs_taken));
                    signs_taken++;
                    r.status = cbs_pkg::ST_SIGN_TAKEN;
                end else if (int'(hb) > slot_idx || slot_idx >= cbs_pkg::POLY_LEN_DEF) begin
                    r.status = cbs_pkg::ST_REJECTED;
                end else begin
                    coef_img[slot_idx] = coef_img[hb];
                    coef_img[hb] = sign_bits[0] ? cbs_pkg::COEF_MINUS : cbs_pkg::COEF_PLUS;
                    sign_bits = sign_bits >> 1;
                    slot_idx++;
                    if (slot_idx >= cbs_pkg::POLY_LEN_DEF) begin
                        ball_done = 1'b1;
                        r.status  = cbs_pkg::ST_PLACED_DONE;
                    end else begin
                        r.status = cbs_pkg::ST_PLACED;
                    end
                end
            end
            cbs_pkg::REQ_READ: begin
                if (int'(ridx) < cbs_pkg::POLY_LEN_DEF) begin
                    if (coef_img[ridx] == cbs_pkg::COEF_PLUS)
                        r.coeff_value = cbs_pkg::COEFF_W'(1);
                    else if (coef_img[ridx] == cbs_pkg::COEF_MINUS)
                        r.coeff_value = cbs_pkg::COEFF_W'(cbs_pkg::MODULUS_DEF - 1);
                end
                r.status = cbs_pkg::ST_READ;
            end
            default: r.status = cbs_pkg::ST_IGNORED;
        endcase
        r.finished = ball_done;
        return r;
    endfunction

    task automatic send_req(input logic [cbs_pkg::REQ_W-1:0] kind,
            input logic [cbs_pkg::BYTE_W-1:0] hb, input logic [cbs_pkg::ADDR_W-1:0] ridx);
        int gap;
        t_sampler_rsp r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.hash_byte  <= hb;
        req_if.read_index <= ridx;
        do @(posedge i_clk); while (!req_if.ready);
        r = predict_sampler_rsp(kind, hb, ridx);
        due_rsp_q.push_back(r);
        items_counted++;
    endtask

    task automatic send_byte(input logic [cbs_pkg::BYTE_W-1:0] hb);
        send_req(cbs_pkg::REQ_BYTE, hb, cbs_pkg::ADDR_W'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [cbs_pkg::ADDR_W-1:0] ridx);
        send_req(cbs_pkg::REQ_READ, cbs_pkg::BYTE_W'($urandom_range(0, 255)), ridx);
    endtask

    task automatic send_start();
        send_req(cbs_pkg::REQ_START, cbs_pkg::BYTE_W'($urandom_range(0, 255)),
                 cbs_pkg::ADDR_W'($urandom_range(0, 255)));
    endtask

    // hash byte biased toward acceptance once the sign word is complete
    task automatic send_sampling_byte();
        logic [cbs_pkg::BYTE_W-1:0] hb;
        if (signs_taken < cbs_pkg::SIGN_BYTES || slot_idx >= cbs_pkg::POLY_LEN_DEF ||
            $urandom_range(0, 3) == 0)
            hb = cbs_pkg::BYTE_W'($urandom_range(0, 255));
        else
            hb = cbs_pkg::BYTE_W'($urandom_range(0, slot_idx));
        send_byte(hb);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (due_rsp_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_nz_count(input logic [cbs_pkg::CNT_W-1:0] v);
        wait_drained();
        cfg_if.valid         <= 1'b1;
        cfg_if.nonzero_count <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        nz_count_reg = v;
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_sampler_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (due_rsp_q.size() == 0) begin
                $display("%0t: unexpected beat, status %0d coeff %0d", $time,
                         rsp_if.status, rsp_if.coeff_value);
                err_cnt++;
            end else begin
                want = due_rsp_q.pop_front();
                if (rsp_if.coeff_value !== want.coeff_value) begin
                    $display("%0t: coeff_value expected %0d actual %0d", $time,
                             want.coeff_value, rsp_if.coeff_value);
                    err_cnt++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_if.status);
                    err_cnt++;
                end
                if (rsp_if.finished !== want.finished) begin
                    $display("%0t: finished expected %0d actual %0d", $time,
                             want.finished, rsp_if.finished);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : rsp_ready_gen
        int mode;
        int run_len;
        forever begin
            if (hold_rsp_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rsp_req = 1'b0;
            end else begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(4, 40);
                for (int k = 0; k < run_len && !hold_rsp_req; k++) begin
                    case (mode)
                        0:       rsp_if.ready <= 1'b1;
                        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                        2:       rsp_if.ready <= (k % 3 != 0);
                        default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_read(8'd0);
        send_read(8'd255);
    endtask

    task automatic test_single_coeff();
        write_nz_count(7'd1);
        send_start();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'd255);
        send_byte(8'd0);
        send_read(8'd255);
    endtask

    task automatic test_zero_count();
        write_nz_count(7'd0);
        send_start();
        send_byte(8'd17);
    endtask

    task automatic test_count_clamp();
        write_nz_count(7'd127);
        send_start();
        repeat (8) send_byte(8'h00);
        send_byte(8'd255);
        send_byte(8'd0);
        send_read(8'd0);
        // new count must not disturb the run in progress
        write_nz_count(7'd1);
        send_byte(8'd1);
    endtask

    task automatic test_unused_code();
        send_req(REQ_UNUSED, 8'hFF, 8'hFF);
    endtask

    task automatic test_response_holdoff();
        write_nz_count(7'd64);
        send_start();
        hold_rsp_req = 1'b1;
        repeat (40) send_sampling_byte();
    endtask

    task automatic test_sender_pause();
        send_start();
        repeat (8) send_sampling_byte();
        wait_drained();
        repeat (12) send_sampling_byte();
        wait_drained();
        send_read(cbs_pkg::ADDR_W'($urandom_range(192, 255)));
    endtask

    task automatic random_poly();
        int r;
        int steps;
        int n;
        send_start();
        steps = 0;
        while (!ball_done && steps < 400) begin
            r = $urandom_range(0, 99);
            steps++;
            if (r < 4) send_read(cbs_pkg::ADDR_W'($urandom_range(0, 255)));
            else if (r < 5) send_req(REQ_UNUSED, cbs_pkg::BYTE_W'($urandom_range(0, 255)),
                                     cbs_pkg::ADDR_W'($urandom_range(0, 255)));
            else if (r < 6) send_start();
            else if (r < 7) write_nz_count(cbs_pkg::CNT_W'($urandom_range(0, 127)));
            else if (r < 8) wait_drained();
            else send_sampling_byte();
        end
        n = $urandom_range(4, 16);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                send_read(cbs_pkg::ADDR_W'($urandom_range(0, 255)));
            else
                send_read(cbs_pkg::ADDR_W'($urandom_range(192, 255)));
        end
        if ($urandom_range(0, 2) == 0) send_byte(cbs_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_sampling();
        int pick;
        items_counted = 0;
        while (items_counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    case ($urandom_range(0, 4))
                        0:       write_nz_count(7'd0);
                        1:       write_nz_count(7'd1);
                        2:       write_nz_count(7'd64);
                        3:       write_nz_count(7'd127);
                        default: write_nz_count(cbs_pkg::CNT_W'($urandom_range(65, 126)));
                    endcase
                end
                1, 2, 3, 4: write_nz_count(cbs_pkg::CNT_W'($urandom_range(1, 64)));
                default: ;
            endcase
            random_poly();
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.req_type      <= cbs_pkg::REQ_START;
        req_if.hash_byte     <= '0;
        req_if.read_index    <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.nonzero_count <= cbs_pkg::NZ_COUNT_RST;
        nz_count_reg = cbs_pkg::NZ_COUNT_RST;
        restart_ball();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_single_coeff();
        test_zero_count();
        test_count_clamp();
        test_unused_code();
        test_response_holdoff();
        test_sender_pause();
        test_random_sampling();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
